// File: sv/set_assoc_cache_lru_lookup_defines.svh
// Assertion macros for the set-associative cache lookup block.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked once out of reset.
`define SACL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked once out of reset.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sacl_pkg.sv
// Shared constants and types for the set-associative cache lookup block.
package sacl_pkg;

    localparam int MAX_WAYS = 8;
    localparam int MAX_SETS = 1024;

    localparam int LIM_BITS = $clog2(MAX_SETS + 1) - 1;
    localparam int ROW_AW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_W    = 32;
    localparam int RANK_W   = 3;
    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

    localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0]  tag;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] row_t;

endpackage

// File: sv/set_assoc_cache_lru_lookup.sv
// Set-associative cache tag lookup with LRU replacement; top level.
// Flow: the accepting edge loads the set row into a register; in the lookup state the
// result enters the output register once it is free; only then is a new item taken
// (a set read, then compare and write-back of that row in the single-port line memory).
// Reset: the line memory is swept one set row per cycle, through all MAX_SETS rows
// (1024), with s_tready low; config writes are taken throughout.
`include "set_assoc_cache_lru_lookup_defines.svh"

module set_assoc_cache_lru_lookup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] address
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] hit, [3:1] way, [4] evicted_valid, [7:5] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    import sacl_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_t;

    state_t state_reg;
    logic [ROW_AW-1:0] clr_cnt_reg;
    logic [3:0] offset_bits_reg, index_bits_reg, ways_in_use_reg;
    logic [ROW_AW-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic out_valid_reg;
    logic out_hit_reg, out_evict_reg;
    logic [2:0] out_way_reg;

    row_t mem [MAX_SETS];
    row_t rd_row_reg;

    logic s_accept, go;
    logic [3:0] ib_eff;
    logic [4:0] ways_eff;
    logic [31:0] idx_mask, shifted;
    logic [ROW_AW-1:0] set_next;
    logic [TAG_W-1:0] tag_next;

    logic mem_we;
    logic [ROW_AW-1:0] mem_wa;
    row_t wr_row, upd_row;

    logic [MAX_WAYS-1:0] in_use, hit_vec, inv_vec;
    logic any_hit, any_inv;
    logic [WAY_W-1:0] hit_way, inv_way, lru_way, target;
    logic [3:0] old_rank;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign go        = (state_reg == ST_LOOKUP) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_evict_reg, out_way_reg, out_hit_reg};

    always_comb begin
        ib_eff = (index_bits_reg > 4'(LIM_BITS)) ? 4'(LIM_BITS) : index_bits_reg;
        if (ways_in_use_reg == 4'd0) begin
            ways_eff = 5'd1;
        end else if ({1'b0, ways_in_use_reg} > 5'(MAX_WAYS)) begin
            ways_eff = 5'(MAX_WAYS);
        end else begin
            ways_eff = {1'b0, ways_in_use_reg};
        end
        idx_mask = ~(32'hFFFF_FFFF << ib_eff);
        shifted  = s_tdata >> offset_bits_reg;
        set_next = ROW_AW'(shifted & idx_mask);
        tag_next = s_tdata >> ({1'b0, offset_bits_reg} + {1'b0, ib_eff});
    end

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w]  = 5'(w) < ways_eff;
            hit_vec[w] = in_use[w] && rd_row_reg[w].valid && (rd_row_reg[w].tag == tag_reg);
            inv_vec[w] = in_use[w] && !rd_row_reg[w].valid;
        end
        any_hit = |hit_vec;
        any_inv = |inv_vec;

        hit_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
        end
        inv_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (inv_vec[w]) begin
                inv_way = WAY_W'(w);
            end
        end
        lru_way = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (in_use[w] && (rd_row_reg[w].rank > rd_row_reg[lru_way].rank)) begin
                lru_way = WAY_W'(w);
            end
        end

        if (any_hit) begin
            target   = hit_way;
            old_rank = {1'b0, rd_row_reg[hit_way].rank};
        end else if (any_inv) begin
            target   = inv_way;
            old_rank = 4'd8;
        end else begin
            target   = lru_way;
            old_rank = {1'b0, rd_row_reg[lru_way].rank};
        end

        upd_row = rd_row_reg;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == target) begin
                upd_row[w].rank = '0;
                if (!any_hit) begin
                    upd_row[w].valid = 1'b1;
                    upd_row[w].tag   = tag_reg;
                end
            end else if (in_use[w] && rd_row_reg[w].valid
                         && ({1'b0, rd_row_reg[w].rank} < old_rank)
                         && (rd_row_reg[w].rank < RANK_MAX)) begin
                upd_row[w].rank = rd_row_reg[w].rank + 1'b1;
            end
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = set_reg;
        wr_row = upd_row;
        if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            wr_row = '0;
        end else if (go) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= wr_row;
        end
        if (s_accept) begin
            rd_row_reg <= mem[set_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            offset_bits_reg <= 4'd5;
            index_bits_reg  <= 4'd6;
            ways_in_use_reg <= 4'd4;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                    CFG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                    CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (go) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ROW_AW'(MAX_SETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        set_reg   <= set_next;
                        tag_reg   <= tag_next;
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    if (go) begin
                        out_hit_reg   <= any_hit;
                        out_way_reg   <= 3'(target);
                        out_evict_reg <= !any_hit && !any_inv;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `SACL_ASSERT_NOW(a_no_accept_in_clear, state_reg == ST_CLEAR, !s_tready, "item accepted during clear")
    `SACL_ASSERT_NEXT(a_accept_to_lookup, s_accept, state_reg == ST_LOOKUP, "accept did not start lookup")
    `SACL_ASSERT_NEXT(a_lookup_gives_result, go, m_tvalid && state_reg == ST_IDLE, "lookup lost result")
    `SACL_ASSERT_NOW(a_hit_no_evict, m_tvalid && m_tdata[0], !m_tdata[4], "hit flagged as eviction")
    `SACL_ASSERT_NOW(a_write_only_when_busy, mem_we, state_reg != ST_IDLE, "line write while idle")

endmodule

// File: verif/tb_top.sv
// Testbench for set_assoc_cache_lru_lookup: lookups checked against a tag/LRU predictor.
`timescale 1ns / 100ps

module tb_top;
    import sacl_pkg::*;

    localparam int          IDX_LIMIT   = $clog2(MAX_SETS + 1) - 1;
    localparam int          RANK_TOP    = 7;
    localparam int          CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       hit;
        logic [2:0] way;
        logic       evicted;
    } lookup_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data  = '0;

    set_assoc_cache_lru_lookup uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [31:0] line_tag   [MAX_SETS*MAX_WAYS];
    bit          line_valid [MAX_SETS*MAX_WAYS];
    int unsigned line_rank  [MAX_SETS*MAX_WAYS];
    logic [3:0]  cur_offset = 4'd5;
    logic [3:0]  cur_index  = 4'd6;
    logic [3:0]  cur_ways   = 4'd4;
    int unsigned eff_index  = 6;
    int unsigned eff_ways   = 4;

    lookup_t pending_lookups[$];
    int      error_count   = 0;
    int      items_sent    = 0;
    int      results_seen  = 0;
    int      hits_seen     = 0;
    int      evicts_seen   = 0;
    int      cfg_writes    = 0;
    int      cycle_count   = 0;
    bit      tx_idle       = 1'b0;
    bit      rx_idle       = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d lookups still pending", $time, pending_lookups.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void promote_way(int unsigned base, int unsigned tgt,
                                        int unsigned old_rank);
        int unsigned w;
        for (w = 0; w < eff_ways; w++) begin
            if (w != tgt && line_valid[base + w] && line_rank[base + w] < old_rank &&
                line_rank[base + w] < RANK_TOP)
                line_rank[base + w]++;
        end
        line_rank[base + tgt] = 0;
    endfunction

    function automatic lookup_t predict_lookup(logic [31:0] addr);
        int unsigned set_no, base, tgt, w;
        logic [31:0] tag;
        bit          found;
        lookup_t     r;
        set_no = (addr >> cur_offset) & ((32'd1 << eff_index) - 1);
        tag    = addr >> (cur_offset + eff_index);
        base   = set_no * MAX_WAYS;
        r      = '0;
        tgt    = 0;
        found  = 1'b0;
        for (w = 0; w < eff_ways; w++) begin
            if (line_valid[base + w] && line_tag[base + w] == tag) begin
                r.hit = 1'b1;
                tgt   = w;
            end
        end
        if (r.hit) begin
            promote_way(base, tgt, line_rank[base + tgt]);
        end else begin
            for (w = 0; w < eff_ways && !found; w++) begin
                if (!line_valid[base + w]) begin
                    tgt   = w;
                    found = 1'b1;
                end
            end
            if (found) begin
                promote_way(base, tgt, RANK_TOP + 1);
            end else begin
                tgt = 0;
                for (w = 1; w < eff_ways; w++)
                    if (line_rank[base + w] > line_rank[base + tgt]) tgt = w;
                r.evicted = 1'b1;
                promote_way(base, tgt, line_rank[base + tgt]);
            end
            line_tag[base + tgt]   = tag;
            line_valid[base + tgt] = 1'b1;
        end
        r.way = 3'(tgt);
        return r;
    endfunction

    function automatic logic [31:0] make_addr(int unsigned set_no, logic [31:0] tag);
        logic [63:0] a;
        a = (64'(tag) << (cur_offset + eff_index)) |
            (64'(set_no & ((32'd1 << eff_index) - 1)) << cur_offset) |
            64'($urandom & ((32'd1 << cur_offset) - 1));
        return a[31:0];
    endfunction

    function automatic logic [31:0] random_addr();
        int unsigned pick, set_no;
        logic [31:0] tag;
        pick = $urandom_range(0, 99);
        if (pick < 10) return $urandom;
        set_no = (pick < 70) ? $urandom_range(0, 3) : $urandom;
        tag    = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, eff_ways + 3);
        return make_addr(set_no, tag);
    endfunction

    task automatic send_item(logic [31:0] addr);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        pending_lookups.push_back(predict_lookup(addr));
        items_sent++;
    endtask

    // stop sending and let every pending result drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // negative value skips that register
    task automatic configure(int off, int idx, int ways, int spare);
        int vals[4];
        int i;
        vals = '{off, idx, ways, spare};
        for (i = 0; i < 4; i++) begin
            if (vals[i] >= 0) begin
                cfg_valid <= 1'b1;
                cfg_index <= 2'(i);
                cfg_data  <= 4'(vals[i]);
                do @(posedge aclk); while (!cfg_ready);
                case (2'(i))
                    CFG_OFFSET_BITS: cur_offset = 4'(vals[i]);
                    CFG_INDEX_BITS:  cur_index  = 4'(vals[i]);
                    CFG_WAYS_IN_USE: cur_ways   = 4'(vals[i]);
                    default: ;
                endcase
                cfg_writes++;
            end
        end
        cfg_valid <= 1'b0;
        eff_index = (cur_index > IDX_LIMIT) ? IDX_LIMIT : cur_index;
        eff_ways  = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways);
    endtask

    // reset settings: fill one set, evict the oldest line, hit again
    task automatic test_basic_lookup();
        int t;
        send_item(32'h0000_0000);
        send_item(32'h0000_0000);
        send_item(32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF);
        for (t = 1; t <= 4; t++) send_item(make_addr(0, t));
        send_item(make_addr(0, 2));
        send_item(make_addr(0, 0));
        settle();
    endtask

    // shrinking the ways lets one tag land in two ways; the higher one must hit
    task automatic test_duplicate_match();
        configure(5, 6, 2, -1);
        send_item(make_addr(3, 7));
        send_item(make_addr(3, 9));
        settle();
        configure(-1, -1, 1, -1);
        send_item(make_addr(3, 9));
        settle();
        configure(-1, -1, 2, -1);
        send_item(make_addr(3, 9));
        send_item(make_addr(3, 7));
        settle();
    endtask

    // widest and narrowest fields, out-of-range index and ways, the spare register index
    task automatic test_config_limits();
        configure(15, 15, 15, 15);
        send_item(make_addr(1023, 0));
        send_item(make_addr(1023, 0));
        send_item(32'hFFFF_FFFF);
        send_item(32'h0000_0000);
        settle();
        configure(0, 0, 0, 0);
        send_item(32'h0000_0000);
        send_item(32'h0000_0000);
        send_item(32'hFFFF_FFFF);
        send_item(32'h0000_0001);
        settle();
    endtask

    task automatic test_random_traffic();
        int p, n;
        for (p = 0; p < 20; p++) begin
            tx_idle = p[0];
            rx_idle = $urandom_range(0, 1);
            configure($urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, 15),
                      $urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, 15),
                      $urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, 15),
                      $urandom_range(0, 7) == 0 ? $urandom_range(0, 15) : -1);
            for (n = 0; n < 52; n++) begin
                if (n == 25 && p % 4 == 0) settle();
                send_item(random_addr());
            end
            settle();
        end
    endtask

    initial begin : result_checker
        logic [7:0] data;
        lookup_t    want;
        int         stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_idle ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            data = m_tdata;
            if (pending_lookups.size() == 0) begin
                $display("%0t: result with no lookup pending, expected none actual %h",
                         $time, data);
                error_count++;
            end else begin
                want = pending_lookups.pop_front();
                if (data[0] !== want.hit) begin
                    $display("%0t: hit mismatch, expected %0d actual %0d",
                             $time, want.hit, data[0]);
                    error_count++;
                end
                if (data[3:1] !== want.way) begin
                    $display("%0t: way mismatch, expected %0d actual %0d",
                             $time, want.way, data[3:1]);
                    error_count++;
                end
                if (data[4] !== want.evicted) begin
                    $display("%0t: evicted_valid mismatch, expected %0d actual %0d",
                             $time, want.evicted, data[4]);
                    error_count++;
                end
                results_seen++;
                if (want.hit) hits_seen++;
                if (want.evicted) evicts_seen++;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_basic_lookup();
        test_duplicate_match();
        test_config_limits();
        test_random_traffic();
        repeat (8) @(posedge aclk);
        $display("Ran %0d lookups, %0d results checked: %0d hits, %0d replaced a valid line,",
                 items_sent, results_seen, hits_seen, evicts_seen);
        $display("across %0d register writes with field widths and ways swept to their limits.",
                 cfg_writes);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
